FILE: hw/rtl/sha_pkg.sv
package sha_pkg;

   typedef logic [31:0] word_type;

   localparam int unsigned RoundCount = 64;
   localparam int unsigned HashWords  = 8;

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type h;
      case (idx)
         3'd0: h = 32'h6a09e667;  3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372;  3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f;  3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;  default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Commands from the byte packer to the compression engine.
   typedef struct packed {
      logic start;   // a full block sits in the block memory
      logic finish;  // after this block, read out the digest
   } comp_cmd_type;

   typedef struct packed {
      logic busy;
   } comp_status_type;

endpackage

FILE: hw/rtl/sha_if.sv
interface sha_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] word_in;
   logic [2:0]  byte_count;
   logic        last_word;
   modport source (output valid, word_in, byte_count, last_word, input ready);
   modport sink (input valid, word_in, byte_count, last_word, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        digest_last;
   modport source (output valid, digest_word, word_index, digest_last, input ready);
   modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

FILE: hw/rtl/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher.
// req channel: one transaction carries word_in with byte_count bytes taken
// from bits 31..24 downward (counts above four act as four) and last_word.
// rsp channel: after the last transaction of a message, eight transactions
// give the digest, word_index 0 first; digest_last marks the eighth.
// Each input transaction is accepted in ST_TAKE and its bytes are pushed one
// by one in ST_PUSH; only then can ST_TAKE accept the next transaction.
// Every 64th byte starts a compression (a load from the block and hash
// memories, 64 rounds and a hash write-back), during which req_ready
// stays low; the rate of a stream of full words is thus set by the byte
// loop and the one-round-per-cycle engine.
// The last transaction adds padding (up to 72 bytes and one or two
// compressions), then a digest readout and a restore of the initial hash
// values.
// After reset, the hash memory is loaded with the initial values in a
// pass (ST_CLEAR of the engine) during which req_ready is low.
// A stalled rsp_ready holds the current digest word and pauses the readout;
// no new message is taken until all eight words have been delivered.
module sha256_stream_hasher_unit (
   input  logic clock,
   input  logic reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);

   sha_pkg::comp_cmd_type    cmd;
   sha_pkg::comp_status_type status;
   logic              blk_we;
   logic [3:0]        blk_waddr;
   sha_pkg::word_type blk_wdata;

   sha_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .status    (status),
      .blk_we    (blk_we),
      .blk_waddr (blk_waddr),
      .blk_wdata (blk_wdata),
      .cmd       (cmd)
   );

   sha_compress u_compress (
      .clock     (clock),
      .reset     (reset),
      .blk_we    (blk_we),
      .blk_waddr (blk_waddr),
      .blk_wdata (blk_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> !status.busy)
      else $error("input accepted while compression busy");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.digest_last == (rsp.word_index == 3'd7)))
      else $error("digest_last does not match word_index");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.digest_last) |=>
      (!rsp.valid || rsp.word_index == $past(rsp.word_index) + 3'd1))
      else $error("digest words out of order");

endmodule

FILE: hw/rtl/sha_compress.sv
// Compression engine. The block words live in a 16-entry memory; the
// hash words in an 8-entry memory. Both have registered reads.
module sha_compress (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      blk_we,
   input  logic [3:0]                blk_waddr,
   input  sha_pkg::word_type         blk_wdata,
   input  sha_pkg::comp_cmd_type     cmd,
   output sha_pkg::comp_status_type  status,
   sha_rsp_if.source                 rsp
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_ROUND = 6'b000100,
      ST_ADD   = 6'b001000,
      ST_OUT   = 6'b010000,
      ST_CLEAR = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   sha_pkg::word_type sched_mem [16];
   sha_pkg::word_type hash_mem [8];

   // Working variables a..h.
   sha_pkg::word_type var_ff [8];
   sha_pkg::word_type var_in [8];
   logic [6:0] cnt_ff, cnt_in;
   logic       finish_ff, finish_in;
   logic       rsp_valid_ff, rsp_valid_in;
   sha_pkg::word_type rsp_word_ff, rsp_word_in;
   logic [2:0] rsp_idx_ff, rsp_idx_in;

   // Schedule words are read through four taps: w[t-16], w[t-15], w[t-7], w[t-2].
   // A shift window of 16 registers holds them; the memory feeds it during load.
   sha_pkg::word_type win_ff [16];
   sha_pkg::word_type win_in [16];
   sha_pkg::word_type sched_rd_ff, hash_rd_ff;

   logic [3:0] sched_raddr;
   logic [2:0] hash_raddr;
   logic       hash_we;
   logic [2:0] hash_waddr;
   sha_pkg::word_type hash_wdata;

   always_ff @(posedge clock) begin
      if (blk_we) begin
         sched_mem[blk_waddr] <= blk_wdata;
      end
      sched_rd_ff <= sched_mem[sched_raddr];
   end

   always_ff @(posedge clock) begin
      if (hash_we) begin
         hash_mem[hash_waddr] <= hash_wdata;
      end
      hash_rd_ff <= hash_mem[hash_raddr];
   end

   sha_pkg::word_type t1, t2, wnew, s0, s1, ch, maj, e, a, x, y;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      finish_in    = finish_ff;
      var_in       = var_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      sched_raddr  = cnt_ff[3:0];
      hash_raddr   = cnt_ff[2:0];
      hash_we      = 1'b0;
      hash_waddr   = cnt_ff[2:0];
      hash_wdata   = '0;

      x    = win_ff[1];
      y    = win_ff[14];
      s0   = sha_pkg::rotr(x, 7) ^ sha_pkg::rotr(x, 18) ^ (x >> 3);
      s1   = sha_pkg::rotr(y, 17) ^ sha_pkg::rotr(y, 19) ^ (y >> 10);
      wnew = s1 + win_ff[9] + s0 + win_ff[0];
      e    = var_ff[4];
      a    = var_ff[0];
      ch   = (e & var_ff[5]) ^ (~e & var_ff[6]);
      maj  = (a & var_ff[1]) ^ (a & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
      t1   = var_ff[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
             + ch + sha_pkg::round_k(cnt_ff[5:0])
             + (cnt_ff < 7'd16 ? win_ff[cnt_ff[3:0]] : win_ff[15]);
      t2   = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22)) + maj;

      if (rsp.valid && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               finish_in = cmd.finish;
               cnt_in    = '0;
               state_in  = ST_LOAD;
            end
         end
         // One read per cycle from each memory; the reads are registered.
         ST_LOAD: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff != 7'd0) begin
               win_in[cnt_ff[3:0] - 4'd1] = sched_rd_ff;
               if (cnt_ff <= 7'd8) begin
                  var_in[cnt_ff[2:0] - 3'd1] = hash_rd_ff;
               end
            end
            if (cnt_ff == 7'd16) begin
               cnt_in   = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            var_in[7] = var_ff[6];
            var_in[6] = var_ff[5];
            var_in[5] = var_ff[4];
            var_in[4] = var_ff[3] + t1;
            var_in[3] = var_ff[2];
            var_in[2] = var_ff[1];
            var_in[1] = var_ff[0];
            var_in[0] = t1 + t2;
            // From round 15 on, the window slides and w[t+1] enters at the end.
            if (cnt_ff >= 7'd15) begin
               for (int i = 0; i < 15; i++) begin
                  win_in[i] = win_ff[i + 1];
               end
               win_in[15] = wnew;
            end
            cnt_in = cnt_ff + 7'd1;
            hash_raddr = 3'd0;
            if (cnt_ff == 7'd63) begin
               cnt_in   = '0;
               state_in = ST_ADD;
            end
         end
         // Read-modify-write of the hash memory; read of entry n+1 overlaps write of n.
         ST_ADD: begin
            hash_raddr = cnt_ff[2:0] + 3'd1;
            hash_we    = 1'b1;
            hash_wdata = hash_rd_ff + var_ff[cnt_ff[2:0]];
            cnt_in     = cnt_ff + 7'd1;
            if (cnt_ff == 7'd7) begin
               cnt_in   = '0;
               state_in = finish_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_OUT: begin
            hash_raddr = cnt_ff[2:0];
            if (!rsp_valid_ff || rsp.ready) begin
               if (cnt_ff[3]) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = hash_rd_ff;
                  rsp_idx_in   = cnt_ff[2:0];
                  cnt_in       = cnt_ff + 7'd1;
                  hash_raddr   = cnt_ff[2:0] + 3'd1;
                  if (cnt_ff[2:0] == 3'd7) begin
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
               end else begin
                  cnt_in = 7'd8;
               end
            end
         end
         ST_CLEAR: begin
            hash_we    = 1'b1;
            hash_wdata = sha_pkg::init_hash(cnt_ff[2:0]);
            cnt_in     = cnt_ff + 7'd1;
            if (cnt_ff == 7'd7) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         finish_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         finish_ff    <= finish_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      var_ff      <= var_in;
      win_ff      <= win_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   assign status.busy     = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.digest_word = rsp_word_ff;
   assign rsp.word_index  = rsp_idx_ff;
   assign rsp.digest_last = (rsp_idx_ff == 3'd7);

endmodule

FILE: hw/rtl/sha_packer.sv
// Byte packer: assembles input bytes and padding into block words.
module sha_packer (
   input  logic                      clock,
   input  logic                      reset,
   sha_req_if.sink                   req,
   input  sha_pkg::comp_status_type  status,
   output logic                      blk_we,
   output logic [3:0]                blk_waddr,
   output sha_pkg::word_type         blk_wdata,
   output sha_pkg::comp_cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_TAKE = 4'b0001,
      ST_PUSH = 4'b0010,
      ST_PAD  = 4'b0100,
      ST_WAIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  fill_ff, fill_in;
   sha_pkg::word_type acc_ff, acc_in;
   sha_pkg::word_type data_ff, data_in;
   logic [2:0]  left_ff, left_in;
   logic        last_ff, last_in;
   logic [3:0]  pad_ff, pad_in;
   logic        lenphase_ff, lenphase_in;
   logic        padding_ff, padding_in;

   logic [2:0]  cnt_sat;
   logic [7:0]  byte_val;
   logic        push;
   sha_pkg::word_type acc_next;

   always_comb begin
      state_in    = state_ff;
      bits_in     = bits_ff;
      fill_in     = fill_ff;
      acc_in      = acc_ff;
      data_in     = data_ff;
      left_in     = left_ff;
      last_in     = last_ff;
      pad_in      = pad_ff;
      lenphase_in = lenphase_ff;
      padding_in  = padding_ff;
      cmd         = '0;
      push        = 1'b0;
      byte_val    = '0;
      cnt_sat     = (req.byte_count > 3'd4) ? 3'd4 : req.byte_count;

      case (state_ff)
         ST_TAKE: begin
            if (req.valid) begin
               bits_in = bits_ff + {58'd0, cnt_sat, 3'd0};
               data_in = req.word_in;
               left_in = cnt_sat;
               last_in = req.last_word;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (left_ff != 3'd0) begin
               push     = 1'b1;
               byte_val = data_ff[31:24];
               data_in  = data_ff << 8;
               left_in  = left_ff - 3'd1;
            end else if (last_ff) begin
               push        = 1'b1;
               byte_val    = 8'h80;
               lenphase_in = 1'b0;
               padding_in  = 1'b1;
               state_in    = ST_PAD;
            end else begin
               state_in = ST_TAKE;
            end
         end
         ST_PAD: begin
            push = 1'b1;
            if (!lenphase_ff && fill_ff == 6'd56) begin
               lenphase_in = 1'b1;
               pad_in      = 4'd1;
               byte_val    = bits_ff[63:56];
            end else if (lenphase_ff) begin
               byte_val = bits_ff[63 - 8 * pad_ff[2:0] -: 8];
               pad_in   = pad_ff + 4'd1;
            end
         end
         ST_WAIT: begin
            if (!status.busy) begin
               state_in = ST_PUSH;
               // All eight length bytes are in, so the message is done.
               if (lenphase_ff && pad_ff == 4'd8) begin
                  state_in    = ST_TAKE;
                  bits_in     = '0;
                  last_in     = 1'b0;
                  lenphase_in = 1'b0;
                  pad_in      = '0;
                  padding_in  = 1'b0;
               end else if (padding_ff) begin
                  state_in = ST_PAD;
               end
            end
         end
         default: state_in = ST_TAKE;
      endcase

      acc_next = {acc_ff[23:0], byte_val};
      blk_we    = 1'b0;
      blk_waddr = fill_ff[5:2];
      blk_wdata = acc_next;
      if (push) begin
         acc_in  = acc_next;
         fill_in = fill_ff + 6'd1;
         blk_we  = (fill_ff[1:0] == 2'd3);
         if (fill_ff == 6'd63) begin
            cmd.start  = 1'b1;
            cmd.finish = lenphase_ff && (pad_ff == 4'd7);
            state_in   = ST_WAIT;
         end
      end
   end

   assign req.ready = (state_ff == ST_TAKE) && !status.busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_TAKE;
         bits_ff     <= '0;
         fill_ff     <= '0;
         last_ff     <= 1'b0;
         left_ff     <= '0;
         pad_ff      <= '0;
         lenphase_ff <= 1'b0;
         padding_ff  <= 1'b0;
      end else begin
         state_ff    <= (state_ff == ST_TAKE && !req.ready) ? ST_TAKE : state_in;
         bits_ff     <= (state_ff == ST_TAKE && !req.ready) ? bits_ff : bits_in;
         fill_ff     <= fill_in;
         last_ff     <= (state_ff == ST_TAKE && !req.ready) ? last_ff : last_in;
         left_ff     <= (state_ff == ST_TAKE && !req.ready) ? left_ff : left_in;
         pad_ff      <= pad_in;
         lenphase_ff <= lenphase_in;
         padding_ff  <= padding_in;
      end
      acc_ff  <= acc_in;
      data_ff <= (state_ff == ST_TAKE && !req.ready) ? data_ff : data_in;
   end

endmodule
